@@ rtl/core/mtkc_pkg.sv @@
// Shared types, constants and tempering function for the MT19937 byte cipher.
// No dependencies.
package mtkc_pkg;

  localparam int unsigned MtN = 624;
  localparam int unsigned MtM = 397;
  localparam int unsigned IdxW = 10;
  localparam logic [31:0] MtMatrix = 32'h9908_B0DF;
  localparam logic [31:0] MtUpper = 32'h8000_0000;
  localparam logic [31:0] MtLower = 32'h7FFF_FFFF;
  localparam logic [31:0] MtInitMult = 32'd1812433253;
  localparam logic [31:0] KeyMask = 32'hA9C3_6DE1;
  localparam int unsigned KeyShift = 7;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MtN - 1);
  localparam logic [IdxW-1:0] MOff = IdxW'(MtM);
  localparam logic [IdxW-1:0] MWrap = IdxW'(MtN - MtM);

  // one classified request handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    logic        reseed;
    logic [31:0] key;
  } cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ rtl/core/mtkc_front.sv @@
// Front end: two-entry request queue that accepts and classifies input bytes.
// Depends on mtkc_pkg.
module mtkc_front import mtkc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [31:0] in_key_seed,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        q_r[wp_r] <= '{data: in_data_byte, reseed: in_first_byte, key: in_key_seed};
        wp_r      <= ~wp_r;
      end
      if (cmd_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(cmd_take);
    end
  end

endmodule

@@ rtl/core/mtkc_back.sv @@
// Back end: generator state memory, reseed sequencer and per-byte twist/temper.
// Depends on mtkc_pkg.
module mtkc_back import mtkc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  input  logic       res_room,
  output logic       res_push,
  output logic [7:0] res_byte
);

  typedef enum logic [2:0] {
    S_IDLE, S_SMUL, S_SADD, S_RA, S_RB, S_RC, S_WR, S_OUT
  } state_t;

  logic [31:0]     mem [MtN];
  state_t          state_r;
  logic [IdxW-1:0] idx_r, sidx_r;
  logic [31:0]     p_r, prod_r, rdata_r, a_r, b_r, tw_r;
  logic [7:0]      data_r;
  logic [IdxW-1:0] idx1, idxm, raddr, waddr;
  logic            we;
  logic [31:0]     wdata, y, v, seed;
  logic [31:0]     tw_tempered;

  assign idx1  = (idx_r == LastIdx) ? '0 : idx_r + 1'b1;
  assign idxm  = (idx_r >= MWrap) ? idx_r - MWrap : idx_r + MOff;
  assign seed  = (cmd.key << KeyShift) ^ KeyMask;
  assign y     = (a_r & MtUpper) | (b_r & MtLower);
  assign v     = rdata_r ^ (y >> 1) ^ (y[0] ? MtMatrix : 32'd0);

  always_comb begin
    unique case (state_r)
      S_RB:    raddr = idx1;
      S_RC:    raddr = idxm;
      default: raddr = idx_r;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = v;
    unique case (state_r)
      S_IDLE: if (cmd_valid && res_room && cmd.reseed) begin
        we = 1'b1; waddr = '0; wdata = seed;
      end
      S_SADD: begin
        we = 1'b1; waddr = sidx_r; wdata = prod_r + 32'(sidx_r);
      end
      S_WR: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign cmd_take    = (state_r == S_OUT);
  assign res_push    = (state_r == S_OUT);
  assign tw_tempered = temper(tw_r);
  assign res_byte    = data_r ^ tw_tempered[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      sidx_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (cmd_valid && res_room) begin
          data_r <= cmd.data;
          if (cmd.reseed) begin
            p_r     <= seed;
            sidx_r  <= IdxW'(1);
            state_r <= S_SMUL;
          end else begin
            state_r <= S_RA;
          end
        end
        S_SMUL: begin
          prod_r  <= MtInitMult * (p_r ^ (p_r >> 30));
          state_r <= S_SADD;
        end
        S_SADD: begin
          p_r <= prod_r + 32'(sidx_r);
          if (sidx_r == LastIdx) begin
            idx_r   <= '0;
            state_r <= S_RA;
          end else begin
            sidx_r  <= sidx_r + 1'b1;
            state_r <= S_SMUL;
          end
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          a_r     <= rdata_r;
          state_r <= S_RC;
        end
        S_RC: begin
          b_r     <= rdata_r;
          state_r <= S_WR;
        end
        S_WR: begin
          tw_r    <= v;
          state_r <= S_OUT;
        end
        S_OUT: begin
          idx_r   <= idx1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/mt19937_keystream_byte_cipher.sv @@
// Top level of the MT19937 keystream byte cipher: front queue, generator back
// end and a two-entry result queue. Depends on mtkc_pkg, mtkc_front, mtkc_back.

// Self-inverse byte cipher: each byte is XORed with the low byte of the next
// tempered MT19937 output. A byte with in_first_byte high reseeds the generator
// from ((in_key_seed << 7) ^ 0xA9C36DE1) first. A plain byte passes through
// the back end in order: the start step, three reads of the state memory, one
// twist write and the output step. A reseeding byte first runs the init pass,
// which fills each of the 623 words after the seed with a multiply step, then
// an add and write step.
// Input and result sides are queues of two requests each, so either side may
// stall without blocking the other. Bytes sent before the first reseed after
// reset give undefined results.
module mt19937_keystream_byte_cipher import mtkc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [31:0] in_key_seed,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte
);

  cmd_t       cmd;
  logic       cmd_valid, cmd_take;
  logic       res_push;
  logic [7:0] res_byte;

  logic [7:0] oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       do_pop;

  mtkc_front u_front (
    .clk, .rst_n, .push, .full,
    .in_data_byte, .in_first_byte, .in_key_seed,
    .cmd_valid, .cmd, .cmd_take
  );

  // start a request only while the result queue has a free slot
  mtkc_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .res_room(ocnt_r != 2'd2), .res_push, .res_byte
  );

  assign empty    = (ocnt_r == 2'd0);
  assign out_byte = oq_r[orp_r];
  assign do_pop   = pop && !empty;

  // hold finished bytes until the consumer pops them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (res_push) begin
        oq_r[owp_r] <= res_byte;
        owp_r       <= ~owp_r;
      end
      if (do_pop) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + 2'(res_push) - 2'(do_pop);
    end
  end

  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3) else $error("result queue count out of range");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (ocnt_r != 2'd2 || do_pop)) else $error("result queue overflow");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid) else $error("back end took request from empty queue");

endmodule
